// ===== design/assert_macros.svh =====
// Assertion macros shared by the temporal window sum threshold design.
// Included by twst_datapath, the module that carries concurrent assertions; needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk once reset has been released.
`define TWST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every rising edge of clk, including while reset is held.
`define TWST_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== design/twst_pkg.sv =====
// Shared constants, types and codes for the temporal window sum threshold block.
// Used by twst_ctrl, twst_datapath and temporal_window_sum_threshold; depends on nothing.
package twst_pkg;

    // Sizing of the history ring and the frame.
    localparam int MAX_LENGTH = 16;
    localparam int MAX_PIXELS = 65536;

    // Fixed field widths.
    localparam int PIX_W      = 8;
    localparam int PIX_MAX    = 255;
    localparam int WL_FIELD_W = 5;
    localparam int TH_W       = 5;
    localparam int FP_FIELD_W = 17;
    localparam int CFG_W      = 17;
    localparam int REG_IDX_W  = 2;

    // Widths derived from the sizing constants.
    localparam int LEN_W   = $clog2(MAX_LENGTH + 1);
    localparam int SLOT_W  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int WRAP_W  = LEN_W + 1;
    localparam int POS_W   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int FP_W    = $clog2(MAX_PIXELS + 1);
    localparam int HIST_AW = SLOT_W + POS_W;
    localparam int SUM_W   = $clog2(MAX_LENGTH * PIX_MAX + 1);
    localparam int THR_P_W = TH_W + PIX_W;
    localparam int LEN_P_W = LEN_W + PIX_W;
    localparam int CMP_W0  = (THR_P_W > LEN_P_W) ? THR_P_W : LEN_P_W;
    localparam int CMP_W   = (CMP_W0 > SUM_W) ? CMP_W0 : SUM_W;

    // Register reset values, clipped into their legal ranges.
    localparam int WL_RESET = (8 > MAX_LENGTH) ? MAX_LENGTH : 8;
    localparam int TH_RESET = 4;
    localparam int FP_RESET = (65536 > MAX_PIXELS) ? MAX_PIXELS : 65536;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_PIXELS  = 2'd2;

    // Input word opcodes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_REPLAY,
        ST_RESULT
    } twst_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // load a pixel word and start its work
        logic clear_hist;  // clear-history word accepted
        logic clr_step;    // write one zero of the output map sweep
        logic sum_step;    // issue/collect history reads
        logic map_read;    // read the stored output bit
        logic commit;      // finish the word: write memories, load result
    } twst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic sum_done;
        logic out_free;
    } twst_status_t;

endpackage

// ===== design/twst_ctrl.sv =====
// Controller state machine of the temporal window sum threshold block.
// Depends on twst_pkg; drives twst_datapath through command and status structs.
module twst_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   opcode,
    input  logic                   static_frame,
    input  twst_pkg::twst_status_t status,
    output twst_pkg::twst_cmd_t    cmd
);

    twst_pkg::twst_state_t state_reg;
    twst_pkg::twst_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= twst_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            twst_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = twst_pkg::ST_IDLE;
                end
            end
            twst_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (opcode == twst_pkg::OP_CLEAR)
                    begin
                        cmd.clear_hist = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = static_frame ? twst_pkg::ST_REPLAY : twst_pkg::ST_SUM;
                    end
                end
            end
            twst_pkg::ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (status.sum_done)
                begin
                    state_next = twst_pkg::ST_RESULT;
                end
            end
            twst_pkg::ST_REPLAY:
            begin
                cmd.map_read = 1'b1;
                state_next   = twst_pkg::ST_RESULT;
            end
            twst_pkg::ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = twst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = twst_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/twst_datapath.sv =====
// Datapath of the temporal window sum threshold block: registers, history ring
// memory, output map memory, accumulator and output register. Depends on twst_pkg.
`include "assert_macros.svh"

module twst_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  twst_pkg::twst_cmd_t                cmd,
    output twst_pkg::twst_status_t             status,
    input  logic [twst_pkg::PIX_W-1:0]         pixel_in,
    input  logic                               static_frame,
    input  logic                               cfg_we,
    input  logic [twst_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [twst_pkg::CFG_W-1:0]         cfg_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [twst_pkg::PIX_W-1:0]         pixel_out,
    output logic                               frame_last
);

    localparam int HIST_DEPTH = 1 << twst_pkg::HIST_AW;
    localparam int OMAP_DEPTH = 1 << twst_pkg::POS_W;

    // Configuration and control state.
    logic [twst_pkg::LEN_W-1:0]   window_length_reg;
    logic [twst_pkg::TH_W-1:0]    threshold_reg;
    logic [twst_pkg::FP_W-1:0]    frame_pixels_reg;
    logic [twst_pkg::LEN_W-1:0]   frames_held_reg;
    logic [twst_pkg::LEN_W-1:0]   frames_held_next;
    logic [twst_pkg::SLOT_W-1:0]  ring_head_reg;
    logic [twst_pkg::POS_W-1:0]   pos_reg;
    logic [twst_pkg::POS_W-1:0]   clr_addr_reg;
    logic [twst_pkg::LEN_W-1:0]   k_reg;
    logic                         pend_reg;
    logic                         out_valid_reg;

    // Payload registers.
    logic [twst_pkg::PIX_W-1:0]   pixel_reg;
    logic                         static_reg;
    logic [twst_pkg::SUM_W-1:0]   sum_reg;
    logic [twst_pkg::PIX_W-1:0]   hist_rdata_reg;
    logic                         omap_rdata_reg;
    logic [twst_pkg::PIX_W-1:0]   pixel_out_reg;
    logic                         frame_last_reg;

    // Memories.
    logic [twst_pkg::PIX_W-1:0]   hist_mem [HIST_DEPTH];
    logic                         omap_mem [OMAP_DEPTH];

    // Combinational helpers.
    logic [twst_pkg::WL_FIELD_W-1:0] wl_raw;
    logic [twst_pkg::FP_FIELD_W-1:0] fp_raw;
    logic [twst_pkg::LEN_W-1:0]      wl_clamped;
    logic [twst_pkg::FP_W-1:0]       fp_clamped;
    logic [twst_pkg::WRAP_W-1:0]     slot_wide;
    logic [twst_pkg::SLOT_W-1:0]     read_slot;
    logic                            issue;
    logic                            last;
    logic [twst_pkg::CMP_W-1:0]      sum_ext;
    logic [twst_pkg::CMP_W-1:0]      thr_ext;
    logic [twst_pkg::CMP_W-1:0]      len_ext;
    logic [twst_pkg::CMP_W-1:0]      thr_prod;
    logic [twst_pkg::CMP_W-1:0]      len_prod;
    logic                            pass;
    logic                            result_bit;
    logic                            hist_we;
    logic                            omap_we;
    logic [twst_pkg::POS_W-1:0]      omap_waddr;
    logic                            omap_wdata;

    // Configuration values clipped into their legal ranges.
    always_comb
    begin
        wl_raw = cfg_data[twst_pkg::WL_FIELD_W-1:0];
        fp_raw = cfg_data[twst_pkg::FP_FIELD_W-1:0];
        if (wl_raw == '0)
        begin
            wl_clamped = twst_pkg::LEN_W'(1);
        end
        else if (32'(wl_raw) > twst_pkg::MAX_LENGTH)
        begin
            wl_clamped = twst_pkg::LEN_W'(twst_pkg::MAX_LENGTH);
        end
        else
        begin
            wl_clamped = twst_pkg::LEN_W'(wl_raw);
        end
        if (fp_raw == '0)
        begin
            fp_clamped = twst_pkg::FP_W'(1);
        end
        else if (32'(fp_raw) > twst_pkg::MAX_PIXELS)
        begin
            fp_clamped = twst_pkg::FP_W'(twst_pkg::MAX_PIXELS);
        end
        else
        begin
            fp_clamped = twst_pkg::FP_W'(fp_raw);
        end
    end

    // Ring slot of the frame k steps back from the current head.
    always_comb
    begin
        slot_wide = twst_pkg::WRAP_W'(ring_head_reg) + twst_pkg::WRAP_W'(twst_pkg::MAX_LENGTH)
                    - twst_pkg::WRAP_W'(k_reg);
        if (32'(slot_wide) >= twst_pkg::MAX_LENGTH)
        begin
            slot_wide = slot_wide - twst_pkg::WRAP_W'(twst_pkg::MAX_LENGTH);
        end
        read_slot = slot_wide[twst_pkg::SLOT_W-1:0];
    end

    assign issue = cmd.sum_step && (k_reg < window_length_reg);
    assign last  = (twst_pkg::FP_W'(pos_reg) + twst_pkg::FP_W'(1)) >= frame_pixels_reg;

    // Threshold decision: the products by 255 are a shift and a subtract.
    always_comb
    begin
        sum_ext    = twst_pkg::CMP_W'(sum_reg);
        thr_ext    = twst_pkg::CMP_W'(threshold_reg);
        len_ext    = twst_pkg::CMP_W'(window_length_reg);
        thr_prod   = (thr_ext << twst_pkg::PIX_W) - thr_ext;
        len_prod   = (len_ext << twst_pkg::PIX_W) - len_ext;
        pass       = (frames_held_reg >= window_length_reg) &&
                     (sum_ext >= thr_prod) && (sum_ext <= len_prod);
        result_bit = static_reg ? omap_rdata_reg : pass;
    end

    // Frame count: clipped by a length write, cleared by opcode, raised at the end of a non-static frame.
    always_comb
    begin
        frames_held_next = frames_held_reg;
        if (cfg_we && (cfg_index == twst_pkg::REG_WINDOW_LENGTH))
        begin
            if (frames_held_reg > wl_clamped)
            begin
                frames_held_next = wl_clamped;
            end
        end
        else if (cmd.clear_hist)
        begin
            frames_held_next = '0;
        end
        else if (cmd.commit && last && !static_reg && (frames_held_reg < window_length_reg))
        begin
            frames_held_next = frames_held_reg + twst_pkg::LEN_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= twst_pkg::LEN_W'(twst_pkg::WL_RESET);
            threshold_reg     <= twst_pkg::TH_W'(twst_pkg::TH_RESET);
            frame_pixels_reg  <= twst_pkg::FP_W'(twst_pkg::FP_RESET);
            frames_held_reg   <= '0;
            ring_head_reg     <= '0;
            pos_reg           <= '0;
            clr_addr_reg      <= '0;
            k_reg             <= '0;
            pend_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            frames_held_reg <= frames_held_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    twst_pkg::REG_WINDOW_LENGTH: window_length_reg <= wl_clamped;
                    twst_pkg::REG_THRESHOLD:     threshold_reg <= cfg_data[twst_pkg::TH_W-1:0];
                    twst_pkg::REG_FRAME_PIXELS:  frame_pixels_reg <= fp_clamped;
                    default:                     ;
                endcase
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + twst_pkg::POS_W'(1);
            end
            if (cmd.capture)
            begin
                k_reg <= twst_pkg::LEN_W'(1);
            end
            else if (issue)
            begin
                k_reg <= k_reg + twst_pkg::LEN_W'(1);
            end
            pend_reg <= issue;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (last)
                begin
                    pos_reg <= '0;
                    if (!static_reg)
                    begin
                        if (32'(ring_head_reg) == twst_pkg::MAX_LENGTH - 1)
                        begin
                            ring_head_reg <= '0;
                        end
                        else
                        begin
                            ring_head_reg <= ring_head_reg + twst_pkg::SLOT_W'(1);
                        end
                    end
                end
                else
                begin
                    pos_reg <= pos_reg + twst_pkg::POS_W'(1);
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: word capture, accumulator and result word.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pixel_reg  <= pixel_in;
            static_reg <= static_frame;
            sum_reg    <= twst_pkg::SUM_W'(pixel_in);
        end
        else if (pend_reg)
        begin
            sum_reg <= sum_reg + twst_pkg::SUM_W'(hist_rdata_reg);
        end
        if (cmd.commit)
        begin
            pixel_out_reg  <= result_bit ? twst_pkg::PIX_W'(twst_pkg::PIX_MAX) : '0;
            frame_last_reg <= last;
        end
    end

    // History ring memory: one read per cycle while summing, one write at the commit of a non-static word.
    assign hist_we = cmd.commit && !static_reg;

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[{ring_head_reg, pos_reg}] <= pixel_reg;
        end
        if (issue)
        begin
            hist_rdata_reg <= hist_mem[{read_slot, pos_reg}];
        end
    end

    // Output map memory: zeroed by the sweep after reset, written at the commit of a non-static word.
    assign omap_we    = cmd.clr_step || (cmd.commit && !static_reg);
    assign omap_waddr = cmd.clr_step ? clr_addr_reg : pos_reg;
    assign omap_wdata = cmd.clr_step ? 1'b0 : pass;

    always_ff @(posedge clk)
    begin
        if (omap_we)
        begin
            omap_mem[omap_waddr] <= omap_wdata;
        end
        if (cmd.map_read)
        begin
            omap_rdata_reg <= omap_mem[pos_reg];
        end
    end

    // Status back to the controller.
    assign status.clear_done = (32'(clr_addr_reg) == twst_pkg::MAX_PIXELS - 1);
    assign status.sum_done   = (k_reg >= window_length_reg) && !pend_reg;
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign frame_last = frame_last_reg;

    // The frame count never runs past the window length.
    `TWST_ASSERT(a_held_in_window, frames_held_reg <= window_length_reg, "frames_held above length")
    // A result is loaded only when the output register is free or being emptied.
    `TWST_ASSERT(a_commit_free, cmd.commit |-> (!out_valid_reg || !out_stall), "result overwritten")
    // A commit always leaves a valid result word behind it.
    `TWST_ASSERT(a_commit_valid, cmd.commit |=> out_valid_reg, "committed result not shown")
    // No history read is collected while a new word is being loaded.
    `TWST_ASSERT_ALWAYS(a_no_pend_on_load, !(cmd.capture && pend_reg), "read pending at load")

endmodule

// ===== design/temporal_window_sum_threshold.sv =====
// Top level of the temporal window sum threshold block.
// Depends on twst_pkg, twst_ctrl and twst_datapath.
//
//  Channel  Handshake             Payload
//  -------  --------------------  ------------------------------------
//  in       in_valid / in_stall   opcode, pixel_in, static_frame
//  out      out_valid / out_stall pixel_out, frame_last
//  cfg      cfg_we                cfg_index, cfg_data
//
// A pixel word is accepted in ST_IDLE; in ST_SUM the ring memory is then read once for
// each earlier frame of the window, the last read is collected and the sum is seen to be
// complete, and in ST_RESULT the word is committed. A static word replays its stored bit
// in ST_REPLAY instead; a clear-history word is taken in ST_IDLE alone.
// After reset all MAX_PIXELS (65536) output map bits are zeroed with in_stall high.
// A waiting result does not block the next word; only its commit waits for out_stall.
module temporal_window_sum_threshold (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           opcode,
    input  logic [twst_pkg::PIX_W-1:0]     pixel_in,
    input  logic                           static_frame,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [twst_pkg::PIX_W-1:0]     pixel_out,
    output logic                           frame_last,
    input  logic                           cfg_we,
    input  logic [twst_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [twst_pkg::CFG_W-1:0]     cfg_data
);

    twst_pkg::twst_cmd_t    cmd;
    twst_pkg::twst_status_t status;

    // Sequencer.
    twst_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .static_frame (static_frame),
        .status       (status),
        .cmd          (cmd)
    );

    // Registers, memories and arithmetic.
    twst_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .pixel_in     (pixel_in),
        .static_frame (static_frame),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_out    (pixel_out),
        .frame_last   (frame_last)
    );

endmodule

// ===== verif/tb_temporal_window_sum_threshold.sv =====
// Self-checking testbench for the temporal window sum threshold block.
// Depends on twst_pkg and the RTL; streams mask frames through it and checks each output word.
module tb_temporal_window_sum_threshold;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1_200_000;
    localparam int SETTLE_CYCLES = twst_pkg::MAX_LENGTH + 8;
    // Positions below this count have every ring slot written during priming.
    localparam int PRIMED_PIXELS = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [twst_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [twst_pkg::PIX_W-1:0] PIX_ON = twst_pkg::PIX_W'(twst_pkg::PIX_MAX);

    typedef struct packed {
        logic [twst_pkg::PIX_W-1:0] level;
        logic                       frame_end;
    } mask_word_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic                           opcode;
    logic [twst_pkg::PIX_W-1:0]     pixel_in;
    logic                           static_frame;
    logic                           out_valid;
    logic                           out_stall;
    logic [twst_pkg::PIX_W-1:0]     pixel_out;
    logic                           frame_last;
    logic                           cfg_we;
    logic [twst_pkg::REG_IDX_W-1:0] cfg_index;
    logic [twst_pkg::CFG_W-1:0]     cfg_data;

    // Mirror of the block state used to predict every output word.
    bit [twst_pkg::PIX_W-1:0] ring_mem [twst_pkg::MAX_LENGTH][twst_pkg::MAX_PIXELS];
    bit                       map_bits [twst_pkg::MAX_PIXELS];
    int unsigned    held_frames;
    int unsigned    head_slot;
    int unsigned    cur_pos;
    int unsigned    win_len;
    int unsigned    thr_units;
    int unsigned    frame_size;

    mask_word_t results_due[$];

    int  mismatches;
    int  results_checked;
    int  words_sent;
    int  clear_words;
    int  static_words;
    int  settings_used;
    int  cycle_count;
    int  rx_hold_request;
    bit  tx_quiet;
    bit  rx_quiet;

    temporal_window_sum_threshold DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .pixel_in     (pixel_in),
        .static_frame (static_frame),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_out    (pixel_out),
        .frame_last   (frame_last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Timeout: a hung block ends the run here.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("temporal_window_sum_threshold test failed");
        $finish;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_idle(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mask pixel: mostly 0 or 255 with the given share of 255, sometimes any value.
    function automatic logic [twst_pkg::PIX_W-1:0] pick_pixel(input int pct_on);
        if ($urandom_range(0, 99) < 8)
            return twst_pkg::PIX_W'($urandom_range(0, twst_pkg::PIX_MAX));
        return ($urandom_range(0, 99) < pct_on) ? PIX_ON : '0;
    endfunction

    // Moving-sum threshold predictor: updates the mirror and queues the expected word.
    function automatic void predict_mask_word(input logic op,
                                              input logic [twst_pkg::PIX_W-1:0] pix,
                                              input logic stat);
        int unsigned                pos;
        int unsigned                sum;
        int unsigned                slot;
        logic [twst_pkg::PIX_W-1:0] lvl;
        logic                       fend;
        words_sent++;
        if (op == twst_pkg::OP_CLEAR)
        begin
            clear_words++;
            held_frames = 0;
            return;
        end
        pos = cur_pos % twst_pkg::MAX_PIXELS;
        if (stat)
        begin
            // Static pixel: replay the stored decision, leave the memories alone.
            static_words++;
            lvl = map_bits[pos] ? PIX_ON : '0;
        end
        else
        begin
            sum = pix;
            for (int k = 1; k < win_len; k++)
            begin
                slot = (head_slot + twst_pkg::MAX_LENGTH - k) % twst_pkg::MAX_LENGTH;
                sum += ring_mem[slot][pos];
            end
            ring_mem[head_slot][pos] = pix;
            if (held_frames >= win_len && sum >= thr_units * twst_pkg::PIX_MAX &&
                sum <= win_len * twst_pkg::PIX_MAX)
                lvl = PIX_ON;
            else
                lvl = '0;
            map_bits[pos] = (lvl != 0);
        end
        // Frame end bookkeeping.
        fend = (cur_pos + 1 >= frame_size);
        if (fend)
        begin
            cur_pos = 0;
            if (!stat)
            begin
                if (held_frames < win_len)
                    held_frames++;
                head_slot = (head_slot + 1) % twst_pkg::MAX_LENGTH;
            end
        end
        else
        begin
            cur_pos++;
        end
        results_due.push_back('{level: lvl, frame_end: fend});
    endfunction

    // Offer one word, wait for it to be taken, then maybe idle.
    task automatic send_word(input logic op, input logic [twst_pkg::PIX_W-1:0] pix,
                             input logic stat);
        int gap;
        opcode       <= op;
        pixel_in     <= pix;
        static_frame <= stat;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_mask_word(op, pix, stat);
        gap = pick_idle(tx_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every expected word is out and the block is idle.
    task automatic settle_block;
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the caller lowers cfg_we after the last one.
    task automatic write_reg(input logic [twst_pkg::REG_IDX_W-1:0] idx,
                             input logic [twst_pkg::CFG_W-1:0] data);
        int unsigned field;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            twst_pkg::REG_WINDOW_LENGTH:
            begin
                field   = data[twst_pkg::WL_FIELD_W-1:0];
                win_len = (field < 1) ? 1 :
                          (field > twst_pkg::MAX_LENGTH) ? twst_pkg::MAX_LENGTH : field;
                if (held_frames > win_len)
                    held_frames = win_len;
            end
            twst_pkg::REG_THRESHOLD:
            begin
                thr_units = data[twst_pkg::TH_W-1:0];
            end
            twst_pkg::REG_FRAME_PIXELS:
            begin
                field      = data;
                frame_size = (field < 1) ? 1 :
                             (field > twst_pkg::MAX_PIXELS) ? twst_pkg::MAX_PIXELS : field;
            end
            default:
            begin
            end
        endcase
    endtask

    // Wait for idle, then load a full register setting.
    task automatic config_phase(input int wl, input int th, input int fp);
        settle_block();
        write_reg(twst_pkg::REG_WINDOW_LENGTH, twst_pkg::CFG_W'(wl));
        write_reg(twst_pkg::REG_THRESHOLD, twst_pkg::CFG_W'(th));
        write_reg(twst_pkg::REG_FRAME_PIXELS, twst_pkg::CFG_W'(fp));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Whole frames with random content; a few clears and static flips break the pattern.
    task automatic run_frames(input int n_items, input int pct_on, input bit allow_static);
        int sent;
        bit stat_frame;
        bit stat_now;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 6)
                send_word(twst_pkg::OP_CLEAR,
                          twst_pkg::PIX_W'($urandom_range(0, twst_pkg::PIX_MAX)),
                          1'($urandom_range(0, 1)));
            stat_frame = allow_static && ($urandom_range(0, 99) < 12);
            do
            begin
                if (allow_static && $urandom_range(0, 199) == 0)
                    send_word(twst_pkg::OP_CLEAR,
                              twst_pkg::PIX_W'($urandom_range(0, twst_pkg::PIX_MAX)),
                              1'($urandom_range(0, 1)));
                stat_now = stat_frame;
                if (allow_static && $urandom_range(0, 99) < 3)
                    stat_now = !stat_frame;
                send_word(twst_pkg::OP_PIXEL, pick_pixel(pct_on), stat_now);
                sent++;
            end
            while (cur_pos != 0);
        end
    endtask

    // One-pixel frames with saturating writes: window below one, zero threshold.
    task automatic test_unit_frames;
        config_phase(0, 0, 0);
        send_word(twst_pkg::OP_PIXEL, PIX_ON, 1'b0);
        send_word(twst_pkg::OP_PIXEL, '0, 1'b0);
        send_word(twst_pkg::OP_PIXEL, '0, 1'b1);
        send_word(twst_pkg::OP_PIXEL, 8'h5A, 1'b0);
        send_word(twst_pkg::OP_CLEAR, 8'hA5, 1'b1);
        send_word(twst_pkg::OP_PIXEL, PIX_ON, 1'b0);
    endtask

    // Fill every ring slot at the low positions so that no later sum reads unwritten history.
    task automatic test_history_priming;
        config_phase(1, 0, PRIMED_PIXELS);
        run_frames(8 * PRIMED_PIXELS, 50, 1'b0);
        config_phase(1, 1, PRIMED_PIXELS);
        run_frames(8 * PRIMED_PIXELS, 50, 1'b0);
    endtask

    // Window edges: filling, exact and just-below sums, static replay, clear, mixed flags.
    task automatic test_window_edges;
        config_phase(3, 3, 2);
        send_word(twst_pkg::OP_PIXEL, PIX_ON, 1'b0);
        send_word(twst_pkg::OP_PIXEL, PIX_ON, 1'b0);
        send_word(twst_pkg::OP_PIXEL, PIX_ON, 1'b0);
        send_word(twst_pkg::OP_PIXEL, '0, 1'b0);
        send_word(twst_pkg::OP_PIXEL, PIX_ON, 1'b0);
        send_word(twst_pkg::OP_PIXEL, PIX_ON, 1'b0);
        send_word(twst_pkg::OP_PIXEL, 8'd254, 1'b0);
        send_word(twst_pkg::OP_PIXEL, PIX_ON, 1'b0);
        send_word(twst_pkg::OP_PIXEL, '0, 1'b1);
        send_word(twst_pkg::OP_PIXEL, PIX_ON, 1'b1);
        send_word(twst_pkg::OP_CLEAR, '0, 1'b0);
        send_word(twst_pkg::OP_PIXEL, PIX_ON, 1'b0);
        send_word(twst_pkg::OP_PIXEL, PIX_ON, 1'b0);
        send_word(twst_pkg::OP_PIXEL, PIX_ON, 1'b1);
        send_word(twst_pkg::OP_PIXEL, 8'd128, 1'b0);
    endtask

    // Largest frame size, reached by saturation; positions stay inside the primed range.
    task automatic test_largest_frame;
        int n;
        settle_block();
        write_reg(twst_pkg::REG_FRAME_PIXELS, '1);
        write_reg(REG_SPARE, twst_pkg::CFG_W'($urandom_range(0, (1 << twst_pkg::CFG_W) - 1)));
        cfg_we <= 1'b0;
        settings_used++;
        n = PRIMED_PIXELS - 1 - cur_pos;
        repeat (n) send_word(twst_pkg::OP_PIXEL, pick_pixel(85), $urandom_range(0, 4) == 0);
        settle_block();
        write_reg(twst_pkg::REG_FRAME_PIXELS, twst_pkg::CFG_W'(twst_pkg::MAX_PIXELS));
        cfg_we <= 1'b0;
    endtask

    // The receiver holds off for a long stretch while words keep coming.
    task automatic test_output_backpressure;
        config_phase(4, 2, 4);
        tx_quiet = 1'b1;
        rx_hold_request = HOLD_CYCLES;
        run_frames(40, 70, 1'b1);
        tx_quiet = 1'b0;
    endtask

    // Random frames over a series of settings, extremes included.
    task automatic test_random_settings;
        int wl_set [12] = '{8, 16, 31, 16, 1, 1, 2, 5, 4, 12, 3, 7};
        int th_set [12] = '{4, 16, 16, 8, 0, 1, 1, 6, 31, 10, 2, 7};
        int fp_set [12] = '{16, 4, 3, 2, 1, 5, 6, 7, 3, 8, 16, 1};
        int on_set [12] = '{70, 97, 97, 60, 50, 50, 50, 80, 80, 90, 60, 85};
        for (int i = 0; i < 12; i++)
        begin
            config_phase(wl_set[i], th_set[i], fp_set[i]);
            // One stretch runs with no idling on either side.
            tx_quiet = (i == 3);
            rx_quiet = (i == 3);
            run_frames(130, on_set[i], 1'b1);
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // Output side: random stall pattern and a check of every word taken.
    initial
    begin : result_monitor
        mask_word_t want;
        int         run_left;
        int         hold_left;
        bit         run_stall;
        run_left  = 0;
        hold_left = 0;
        run_stall = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    if (mismatches < 50)
                        $display("%0t: unexpected word, pixel_out %0d frame_last %0b",
                                 $time, pixel_out, frame_last);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    results_checked++;
                    if (pixel_out !== want.level)
                    begin
                        if (mismatches < 50)
                            $display("%0t: pixel_out expected %0d, actual %0d",
                                     $time, want.level, pixel_out);
                        mismatches++;
                    end
                    if (frame_last !== want.frame_end)
                    begin
                        if (mismatches < 50)
                            $display("%0t: frame_last expected %0b, actual %0b",
                                     $time, want.frame_end, frame_last);
                        mismatches++;
                    end
                end
            end
            // Next stall value: a requested hold first, then random runs.
            if (rx_hold_request > 0)
            begin
                hold_left = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_quiet)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    if ($urandom_range(0, 99) < 40)
                    begin
                        run_stall = 1'b1;
                        run_left  = 1 + pick_idle(1'b0);
                    end
                    else
                    begin
                        run_stall = 1'b0;
                        run_left  = $urandom_range(1, 10);
                    end
                end
                run_left--;
                out_stall <= run_stall;
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = twst_pkg::OP_PIXEL;
        pixel_in     = '0;
        static_frame = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = twst_pkg::REG_WINDOW_LENGTH;
        cfg_data     = '0;
        mismatches      = 0;
        results_checked = 0;
        words_sent      = 0;
        clear_words     = 0;
        static_words    = 0;
        settings_used   = 0;
        rx_hold_request = 0;
        tx_quiet        = 1'b0;
        rx_quiet        = 1'b0;
        held_frames = 0;
        head_slot   = 0;
        cur_pos     = 0;
        win_len     = twst_pkg::WL_RESET;
        thr_units   = twst_pkg::TH_RESET;
        frame_size  = twst_pkg::FP_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // The output map is swept clear after reset; wait for the input to open.
        @(posedge clk);
        while (in_stall)
            @(posedge clk);

        test_unit_frames();
        test_history_priming();
        test_window_edges();
        test_largest_frame();
        test_output_backpressure();
        test_random_settings();
        settle_block();

        $display("Sent %0d words (%0d clear-history, %0d static pixels) over %0d settings.",
                 words_sent, clear_words, static_words, settings_used);
        $display("Compared %0d output words; %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0 && results_due.size() == 0)
            $display("temporal_window_sum_threshold test passed");
        else
            $display("temporal_window_sum_threshold test failed");
        $finish;
    end

endmodule
